// ===== rtl/grs_pkg.sv =====
// ----------------------------------------------------------------------------
// grs_pkg: shared types and constants for the 1D relaxation grid
// Holds the transaction structs, operation codes and default grid size.
// ----------------------------------------------------------------------------
package grs_pkg;

	localparam int unsigned GRID_INTERVALS_DEF = 1024;
	localparam int unsigned IDX_W   = 11;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned SWEEP_W = 20;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_RUN    = 2'd1,
		OP_READ   = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]              operation;
		logic [IDX_W-1:0]        point_index;
		logic signed [VAL_W-1:0] point_value;
	} cmd_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [1:0]              done_operation;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// Floor average of two signed samples: 33-bit sum shifted right.
	function automatic logic signed [VAL_W-1:0] avg_floor(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		return s[VAL_W:1];
	endfunction

endpackage

// ===== rtl/grs_cell.sv =====
// ----------------------------------------------------------------------------
// grs_cell: one grid point of the relaxation chain
// Holds one sample; loads it, or relaxes it from its two neighbors when
// its update strobe arrives, and passes the strobe on to its right neighbor.
// ----------------------------------------------------------------------------
module grs_cell
	import grs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic signed [VAL_W-1:0] load_value,
	input  logic                    upd_in,
	input  logic signed [VAL_W-1:0] left,
	input  logic signed [VAL_W-1:0] right,
	output logic                    upd_out,
	output logic signed [VAL_W-1:0] value
);

	logic signed [VAL_W-1:0] value_q;
	logic                    upd_q;

	// Sample storage: the left neighbor already holds its new value.
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= load_value;
		end else if (upd_in) begin
			value_q <= avg_floor(right, left);
		end
	end

	// Update token travels one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_q <= 1'b0;
		end else begin
			upd_q <= upd_in;
		end
	end

	assign value   = value_q;
	assign upd_out = upd_q;

endmodule

// ===== rtl/grs_ctrl.sv =====
// ----------------------------------------------------------------------------
// grs_ctrl: sequencer for sweep runs
// Launches one update token per sweep and counts sweeps until done.
// ----------------------------------------------------------------------------
module grs_ctrl
	import grs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               run,
	input  logic [SWEEP_W-1:0] sweep_count,
	input  logic               token_back,
	output logic               launch,
	output logic               busy,
	output logic               finish
);

	state_t             state_q, state_d;
	logic [SWEEP_W-1:0] left_q, left_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
		end
	end

	// Each sweep ends when the token leaves the last interior cell.
	always_comb begin
		state_d = state_q;
		left_d  = left_q;
		launch  = 1'b0;
		finish  = 1'b0;
		busy    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (run) begin
					if (sweep_count == '0) begin
						finish = 1'b1;
					end else begin
						launch  = 1'b1;
						left_d  = sweep_count - 1'b1;
						state_d = ST_SWEEP;
					end
				end
			end
			ST_SWEEP: begin
				busy = 1'b1;
				if (token_back) begin
					if (left_q == '0) begin
						state_d = ST_DONE;
					end else begin
						launch = 1'b1;
						left_d = left_q - 1'b1;
					end
				end
			end
			ST_DONE: begin
				busy    = 1'b1;
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/grid_relaxation_sweep_1d_unit.sv =====
// ----------------------------------------------------------------------------
// grid_relaxation_sweep_1d_unit: 1D Gauss-Seidel relaxation grid
// Top level: a chain of point cells plus a sweep sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low.
//   Write and read commands do not hold busy: the response appears on
//   result with done high in the next cycle, and another command may be
//   issued in that same cycle. A read past the grid returns zero.
//   A run command holds busy high until its last sweep is done; its response
//   then appears with done. Each sweep is one token running down the cell
//   chain one interior point per cycle, so the chain length sets the run
//   time. A run with zero sweeps answers at once. sweep_count must be
//   written through cfg_we/cfg_data only while idle; the block does not enforce it.
//   Reset clears control state and sweep_count; samples are undefined until
//   written. The receiver cannot stall: each response lasts one cycle.
// ----------------------------------------------------------------------------
module grid_relaxation_sweep_1d_unit
	import grs_pkg::*;
#(
	parameter int unsigned GRID_INTERVALS = GRID_INTERVALS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cmd_t               cmd,
	output logic               busy,
	output logic               done,
	output rsp_t               result,
	input  logic               cfg_we,
	input  logic [SWEEP_W-1:0] cfg_data
);

	localparam int unsigned NPTS = GRID_INTERVALS + 1;

	logic [SWEEP_W-1:0]      sweep_q;
	logic                    accept;
	logic                    launch, finish, ctrl_busy;
	logic signed [VAL_W-1:0] pts [NPTS];
	logic                    tok [NPTS];
	logic                    done_q;
	rsp_t                    result_q;
	logic                    in_range;
	logic [IDX_W-1:0]        idx;
	logic signed [VAL_W-1:0] rd_mux;

	assign accept   = start && !ctrl_busy;
	assign idx      = cmd.point_index;
	assign in_range = ({21'd0, idx} <= 32'(GRID_INTERVALS));

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cfg_we) begin
			sweep_q <= cfg_data;
		end
	end

	grs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.run         (accept && cmd.operation == OP_RUN),
		.sweep_count (sweep_q),
		.token_back  (tok[GRID_INTERVALS-1]),
		.launch      (launch),
		.busy        (ctrl_busy),
		.finish      (finish)
	);

	assign tok[0] = launch;

	// End points only load; interior points form the relaxation chain.
	genvar g;
	generate
		for (g = 0; g < NPTS; g++) begin : g_pt
			if (g == 0 || g == NPTS - 1) begin : g_end
				logic signed [VAL_W-1:0] end_q;
				always_ff @(posedge clk) begin
					if (accept && cmd.operation == OP_WRITE && idx == IDX_W'(g)) begin
						end_q <= cmd.point_value;
					end
				end
				assign pts[g] = end_q;
				if (g == NPTS - 1) begin : g_nt
					assign tok[g] = 1'b0;
				end
			end else begin : g_in
				grs_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.load       (accept && cmd.operation == OP_WRITE
					             && idx == IDX_W'(g)),
					.load_value (cmd.point_value),
					.upd_in     (tok[g-1]),
					.left       (pts[g-1]),
					.right      (pts[g+1]),
					.upd_out    (tok[g]),
					.value      (pts[g])
				);
			end
		end
	endgenerate

	// Read select over the grid.
	always_comb begin
		rd_mux = '0;
		if (in_range) begin
			rd_mux = pts[idx];
		end
	end

	// Response register: one-cycle strobe per completed transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish || (accept && cmd.operation != OP_RUN);
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.read_value     <= '0;
			result_q.done_operation <= OP_RUN;
		end else if (accept) begin
			result_q.read_value     <= (cmd.operation == OP_READ) ? rd_mux : '0;
			result_q.done_operation <= cmd.operation;
		end
	end

	assign busy   = ctrl_busy;
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== tb/grid_relaxation_sweep_1d_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_relaxation_sweep_1d_unit_test: self-checking bench for the relaxation grid
// Fills the whole grid, then drives directed and random write, read, run and
// unused commands while changing the sweep count between phases. Every
// response is compared against a behavioral copy of the grid kept here.
// ----------------------------------------------------------------------------
module grid_relaxation_sweep_1d_unit_test;
	import grs_pkg::*;

	localparam int unsigned NPTS = GRID_INTERVALS_DEF;

	// One pending stimulus entry: either a command or a sweep count write.
	typedef struct {
		bit                 is_cfg;
		logic [SWEEP_W-1:0] sweeps;
		cmd_t               cmd;
	} stim_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	cmd_t               cmd;
	logic               busy;
	logic               done;
	rsp_t               result;
	logic               cfg_we;
	logic [SWEEP_W-1:0] cfg_data;

	stim_t                   stim_q[$];
	rsp_t                    expected_rsp[$];
	logic signed [VAL_W-1:0] grid_copy[0:NPTS];
	logic [SWEEP_W-1:0]      sweeps_cur;
	bit                      taken;
	int                      idle_pct;
	int                      errors;
	int                      n_write, n_read, n_run, n_other, n_cfg, n_checked;

	grid_relaxation_sweep_1d_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Floor of the half sum of two signed samples.
	function automatic logic signed [VAL_W-1:0] half_sum(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		longint s;
		s = longint'(a) + longint'(b);
		s = s >>> 1;
		return s[VAL_W-1:0];
	endfunction

	// Apply one accepted command to the grid copy and return its response.
	function automatic rsp_t apply_command(input cmd_t c);
		rsp_t r;
		r.read_value = '0;
		r.done_operation = c.operation;
		case (op_t'(c.operation))
			OP_WRITE: begin
				if (c.point_index <= NPTS)
					grid_copy[c.point_index] = c.point_value;
			end
			OP_RUN: begin
				for (int s = 0; s < sweeps_cur; s++)
					for (int i = 1; i < NPTS; i++)
						grid_copy[i] = half_sum(grid_copy[i+1], grid_copy[i-1]);
			end
			OP_READ: begin
				if (c.point_index <= NPTS)
					r.read_value = grid_copy[c.point_index];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic push_cmd(input op_t op, input int idx, input logic [31:0] val);
		stim_t s;
		s.is_cfg = 1'b0;
		s.sweeps = '0;
		s.cmd.operation = op;
		s.cmd.point_index = idx[IDX_W-1:0];
		s.cmd.point_value = val;
		stim_q.push_back(s);
	endtask

	task automatic push_sweeps(input logic [SWEEP_W-1:0] v);
		stim_t s;
		s.is_cfg = 1'b1;
		s.sweeps = v;
		s.cmd = '0;
		stim_q.push_back(s);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_index();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, NPTS);
		return $urandom_range(NPTS + 1, 2047);
	endfunction

	// Stimulus: full grid fill, directed cases, then random traffic.
	initial begin
		int pick;
		for (int i = 0; i <= NPTS; i++)
			push_cmd(OP_WRITE, i, rand_sample());

		push_sweeps(20'hFFFFF);
		push_cmd(OP_READ, 0, 32'h0);
		push_cmd(OP_READ, NPTS, 32'hFFFF_FFFF);
		push_sweeps(20'h0);
		push_cmd(OP_RUN, 2047, 32'hFFFF_FFFF);
		push_cmd(OP_READ, 512, 32'h0);
		push_cmd(OP_WRITE, 0, 32'h8000_0000);
		push_cmd(OP_WRITE, NPTS, 32'h7FFF_FFFF);
		push_cmd(OP_WRITE, 1, 32'h8000_0000);
		push_cmd(OP_WRITE, 2, 32'h7FFF_FFFF);
		push_cmd(OP_WRITE, 2047, 32'h1234_5678);
		push_cmd(OP_WRITE, NPTS + 1, 32'h0);
		push_cmd(OP_READ, NPTS + 1, 32'h0);
		push_cmd(OP_READ, 2047, 32'h0);
		push_cmd(OP_UNUSED, 2047, 32'hFFFF_FFFF);
		push_cmd(OP_UNUSED, 0, 32'h0);
		push_sweeps(20'h1);
		push_cmd(OP_RUN, 0, 32'h0);
		push_cmd(OP_READ, 1, 32'h0);
		push_cmd(OP_READ, NPTS - 1, 32'h0);
		push_sweeps(20'h3);
		push_cmd(OP_RUN, 5, 32'h0);
		push_cmd(OP_READ, 2, 32'h0);
		push_cmd(OP_READ, NPTS, 32'h0);

		// Random part: mostly reads and writes, runs with small sweep counts.
		for (int n = 0; n < 550; n++) begin
			if (n % 150 == 149)
				push_sweeps($urandom_range(0, 99) < 15 ? 20'h0 : 20'($urandom_range(1, 2)));
			pick = $urandom_range(0, 99);
			if (pick < 40)
				push_cmd(OP_WRITE, rand_index(), rand_sample());
			else if (pick < 87)
				push_cmd(OP_READ, rand_index(), $urandom);
			else if (pick < 95)
				push_cmd(OP_RUN, $urandom_range(0, 2047), $urandom);
			else
				push_cmd(OP_UNUSED, $urandom_range(0, 2047), $urandom);
		end
	end

	// Reset and initial input levels.
	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: inputs change on the falling edge.
	always @(negedge clk) begin
		logic  nxt_start;
		stim_t s;
		nxt_start = start;
		if (arst_n) begin
			if (start && taken)
				nxt_start = 1'b0;
			// Idle level depends on how much stimulus is left.
			case ((stim_q.size() / 400) % 4)
				0: idle_pct = 0;
				1: idle_pct = 64;
				2: idle_pct = 0;
				default: idle_pct = 25;
			endcase
			if (!nxt_start && stim_q.size() > 0
				&& $urandom_range(0, 99) >= idle_pct) begin
				s = stim_q[0];
				if (s.is_cfg) begin
					if (expected_rsp.size() == 0 && !busy && !start) begin
						void'(stim_q.pop_front());
						cfg_data <= s.sweeps;
						cfg_we <= 1'b1;
					end else begin
						cfg_we <= 1'b0;
					end
				end else begin
					void'(stim_q.pop_front());
					cmd <= s.cmd;
					nxt_start = 1'b1;
					cfg_we <= 1'b0;
				end
			end else begin
				cfg_we <= 1'b0;
			end
			start <= nxt_start;
		end
	end

	// Monitor: check responses, then record new transactions.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected response", result, 0);
				end else begin
					want = expected_rsp.pop_front();
					n_checked++;
					if (result.read_value !== want.read_value)
						report_mismatch("read_value", result.read_value, want.read_value);
					if (result.done_operation !== want.done_operation)
						report_mismatch("done_operation", result.done_operation,
							want.done_operation);
				end
			end
			if (cfg_we) begin
				sweeps_cur = cfg_data;
				n_cfg++;
			end
			taken <= start && !busy;
			if (start && !busy) begin
				expected_rsp.push_back(apply_command(cmd));
				case (op_t'(cmd.operation))
					OP_WRITE: n_write++;
					OP_READ:  n_read++;
					OP_RUN:   n_run++;
					default:  n_other++;
				endcase
			end
		end else begin
			sweeps_cur = '0;
			taken <= 1'b0;
		end
	end

	// Completion: drain, settle, report.
	initial begin
		errors = 0;
		@(posedge arst_n);
		repeat (4) @(posedge clk);
		while (stim_q.size() > 0 || start || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d writes, %0d reads, %0d runs, %0d unused commands.",
			n_write, n_read, n_run, n_other);
		$display("Sweep count written %0d times; %0d responses checked, %0d mismatches.",
			n_cfg, n_checked, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog against a hung block.
	initial begin
		#(64'd60_000_000);
		$display("Timeout: %0d commands still pending", stim_q.size());
		$display("Verification failed");
		$finish;
	end

endmodule
